[sv/tlds_pkg.sv]
// ----------------------------------------------------------------------------
// tlds_pkg
// Shared constants for the two-wire LED driver serializer: command bytes,
// request codes and configuration register indexes.
// ----------------------------------------------------------------------------
package tlds_pkg;

  // largest number of segment bytes one transfer can carry
  localparam int MAX_DATA_BYTES_DEF = 4;

  // driver command bytes
  localparam logic [7:0] CMD_DATA = 8'h40;
  localparam logic [7:0] CMD_ADDR = 8'hC0;
  localparam logic [7:0] CMD_CTRL = 8'h80;

  // request codes
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // configuration register indexes
  localparam logic REG_BRIGHTNESS = 1'b0;
  localparam logic REG_DISPLAY_ON = 1'b1;

  // step counts inside one slot
  localparam int BYTE_SLOT_STEPS = 8;
  localparam int BITS_PER_BYTE   = 8;

endpackage

[sv/two_wire_led_driver_serializer.sv]
// ----------------------------------------------------------------------------
// two_wire_led_driver_serializer
// Tick-driven open-drain two-wire write sequencer for a seven-segment LED
// driver: data command, address command, segment bytes, control command.
// ----------------------------------------------------------------------------
// output: each result is registered when its item is accepted
// throughput: one item per cycle when not stalled; the state update for a
//   tick is one narrow compare/add pass feeding the state and result registers
// reset: synchronous; sequencer idle, both lines released high,
//   brightness 7, display on; segment store is not cleared
module two_wire_led_driver_serializer #(
  parameter int MAX_DATA_BYTES = tlds_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  seg_digit0,
  input  logic [7:0]  seg_digit1,
  input  logic [7:0]  seg_digit2,
  input  logic [7:0]  seg_digit3,
  input  logic [2:0]  byte_count,
  input  logic [1:0]  start_position,
  // result item channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        clk_level,
  output logic        dio_level,
  output logic        done_res,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tlds_pkg::*;

  localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
  localparam logic [2:0] MaxBytes = 3'(MAX_DATA_BYTES);

  // configuration registers
  logic [2:0] brightness_level;
  logic       display_on;

  // sequencer state
  logic [6:0] sequence_step;
  logic       transfer_active;
  logic [7:0] shift_byte;
  logic [3:0] bits_left;
  logic       clk_line;
  logic       dio_line;
  logic [7:0] segment_store [MAX_DATA_BYTES];
  logic [2:0] bytes_in_use;
  logic [1:0] digit_address;

  logic [6:0] sequence_step_next;
  logic       transfer_active_next;
  logic [7:0] shift_byte_next;
  logic [3:0] bits_left_next;
  logic       clk_line_next;
  logic       dio_line_next;
  logic       done_next;

  logic       in_acc;
  logic       start_req;
  logic [2:0] count_sat;
  logic [7:0] seg_in [4];

  // region decode
  logic [6:0] data_len;
  logic [6:0] end_step;
  logic [6:0] k_off;
  logic       is_byte;
  logic [2:0] s_step;
  logic [1:0] g_step;
  logic [3:0] bits_dec;
  logic       cfg_wr;

  assign in_stall  = out_valid && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign start_req = (req_type == REQ_START);
  assign count_sat = (byte_count > MaxBytes) ? MaxBytes : byte_count;

  assign seg_in[0] = seg_digit0;
  assign seg_in[1] = seg_digit1;
  assign seg_in[2] = seg_digit2;
  assign seg_in[3] = seg_digit3;

  assign data_len = {1'b0, bytes_in_use, 3'b000};
  assign end_step = 7'd36 + data_len;
  assign k_off    = sequence_step - 7'd20;
  assign bits_dec = bits_left - 4'd1;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_BRIGHTNESS: prdata = {29'd0, brightness_level};
      REG_DISPLAY_ON: prdata = {31'd0, display_on};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_level <= 3'd7;
      display_on       <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BRIGHTNESS: brightness_level <= pwdata[2:0];
        REG_DISPLAY_ON: display_on       <= pwdata[0];
        default:        ;
      endcase
    end
  end

  // next-state logic for one item
  always_comb begin
    sequence_step_next   = sequence_step;
    transfer_active_next = transfer_active;
    shift_byte_next      = shift_byte;
    bits_left_next       = bits_left;
    clk_line_next        = clk_line;
    dio_line_next        = dio_line;
    done_next            = 1'b0;
    is_byte              = 1'b0;
    s_step               = 3'd0;
    g_step               = 2'd0;

    if (start_req) begin
      // start condition: data low, sequence restarts at the data command
      sequence_step_next   = 7'd0;
      transfer_active_next = 1'b1;
      shift_byte_next      = CMD_DATA;
      bits_left_next       = 4'(BITS_PER_BYTE);
      dio_line_next        = 1'b0;
    end else if (!transfer_active || (sequence_step >= end_step)) begin
      // idle or finished: lines hold
      transfer_active_next = 1'b0;
      done_next            = 1'b1;
    end else begin
      // find which slot this step falls in
      priority if (sequence_step < 7'd8) begin
        is_byte = 1'b1;
        s_step  = sequence_step[2:0];
      end else if (sequence_step < 7'd12) begin
        g_step  = 2'(sequence_step - 7'd8);
      end else if (sequence_step < 7'd20) begin
        is_byte = 1'b1;
        s_step  = 3'(sequence_step - 7'd12);
        if (sequence_step == 7'd12) begin
          shift_byte_next = CMD_ADDR + {6'd0, digit_address};
        end
      end else if (sequence_step < 7'd20 + data_len) begin
        is_byte = 1'b1;
        s_step  = k_off[2:0];
        if (k_off[2:0] == 3'd0) begin
          shift_byte_next = segment_store[k_off[3 +: IDX_W]];
        end
      end else if (sequence_step < 7'd24 + data_len) begin
        g_step  = 2'(sequence_step - (7'd20 + data_len));
      end else if (sequence_step < 7'd32 + data_len) begin
        is_byte = 1'b1;
        s_step  = 3'(sequence_step - (7'd24 + data_len));
        if (sequence_step == 7'd24 + data_len) begin
          shift_byte_next = CMD_CTRL + {4'd0, display_on, brightness_level};
        end
      end else begin
        g_step  = 2'(sequence_step - (7'd32 + data_len));
      end

      if (is_byte) begin
        // bit cell: clock low, set data, release clock; then ack slot
        unique case (s_step)
          3'd0: begin
            bits_left_next = 4'(BITS_PER_BYTE);
            clk_line_next  = 1'b0;
          end
          3'd1: clk_line_next = 1'b0;
          3'd2: dio_line_next = shift_byte_next[0];
          3'd3: begin
            clk_line_next   = 1'b1;
            shift_byte_next = {1'b0, shift_byte[7:1]};
            bits_left_next  = bits_dec;
          end
          3'd4: clk_line_next = 1'b0;
          3'd5: clk_line_next = 1'b1;
          3'd7: clk_line_next = 1'b0;
          default: ;
        endcase
        if ((s_step == 3'd3) && (bits_dec != 4'd0)) begin
          sequence_step_next = sequence_step - 7'd2;
        end else begin
          sequence_step_next = sequence_step + 7'd1;
        end
      end else begin
        // stop then start
        unique case (g_step)
          2'd0: dio_line_next = 1'b0;
          2'd1: clk_line_next = 1'b1;
          2'd2: dio_line_next = 1'b1;
          2'd3: dio_line_next = 1'b0;
          default: ;
        endcase
        sequence_step_next = sequence_step + 7'd1;
      end
    end
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_step   <= 7'd0;
      transfer_active <= 1'b0;
      shift_byte      <= 8'd0;
      bits_left       <= 4'd0;
      clk_line        <= 1'b1;
      dio_line        <= 1'b1;
      bytes_in_use    <= 3'd0;
      digit_address   <= 2'd0;
    end else if (in_acc) begin
      sequence_step   <= sequence_step_next;
      transfer_active <= transfer_active_next;
      shift_byte      <= shift_byte_next;
      bits_left       <= bits_left_next;
      clk_line        <= clk_line_next;
      dio_line        <= dio_line_next;
      if (start_req) begin
        bytes_in_use  <= count_sat;
        digit_address <= start_position;
      end
    end
  end

  // segment store, loaded on a start request
  always_ff @(posedge clk) begin
    if (in_acc && start_req) begin
      for (int i = 0; i < MAX_DATA_BYTES; i++) begin
        segment_store[i] <= (3'(i) < count_sat) ? seg_in[i] : 8'd0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      clk_level <= clk_line_next;
      dio_level <= dio_line_next;
      done_res  <= done_next;
    end
  end

  // checks
  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && start_req) |=> (transfer_active && (sequence_step == 7'd0)))
    else $error("start request did not restart the sequencer");

  a_done_means_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !transfer_active)
    else $error("done reported while a transfer is active");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    transfer_active |-> (sequence_step <= end_step))
    else $error("sequence step ran past the end of the transfer");

  a_bits_in_range: assert property (@(posedge clk) disable iff (rst)
    bits_left <= 4'(BITS_PER_BYTE))
    else $error("bit counter out of range");

endmodule

[bench/two_wire_led_driver_serializer_tb.sv]
// ----------------------------------------------------------------------------
// two_wire_led_driver_serializer_tb
// Self-checking bench for the two-wire LED driver serializer. A local line
// model predicts clock level, data level and done for every accepted item,
// and the monitor compares each result against the oldest prediction. The
// bench runs a short directed part and then random transfers. Across phases
// it varies the brightness and display settings and the idle and stall
// rates, including a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module two_wire_led_driver_serializer_tb;
  import tlds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 70;

  typedef struct packed {
    logic       req;
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] d3;
    logic [2:0] count;
    logic [1:0] pos;
  } tick_item_t;

  typedef struct packed {
    logic clk_l;
    logic dio_l;
    logic done;
  } line_result_t;

  // block ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = REQ_TICK;
  logic [7:0]  seg_digit0 = '0;
  logic [7:0]  seg_digit1 = '0;
  logic [7:0]  seg_digit2 = '0;
  logic [7:0]  seg_digit3 = '0;
  logic [2:0]  byte_count = '0;
  logic [1:0]  start_position = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        clk_level;
  logic        dio_level;
  logic        done_res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // stimulus and checking state
  tick_item_t   tick_queue[$];
  line_result_t expected_lines[$];
  tick_item_t   cur_item;
  int           mismatches = 0;
  int           cycles = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  logic         hold_start = 1'b0;
  int           hold_left = 0;

  // line model state
  logic [6:0] seq_step = '0;
  logic       active = 1'b0;
  logic [7:0] shift_reg = '0;
  logic [3:0] bits_left = '0;
  logic       clk_line = 1'b1;
  logic       dio_line = 1'b1;
  logic [7:0] seg_store[4] = '{default: '0};
  logic [2:0] n_bytes = '0;
  logic [1:0] digit_addr = '0;
  logic [2:0] cfg_bright = 3'd7;
  logic       cfg_on = 1'b1;

  two_wire_led_driver_serializer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type),
    .seg_digit0(seg_digit0), .seg_digit1(seg_digit1),
    .seg_digit2(seg_digit2), .seg_digit3(seg_digit3),
    .byte_count(byte_count), .start_position(start_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .clk_level(clk_level), .dio_level(dio_level), .done_res(done_res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // one tick inside a byte slot: three ticks per bit, then the ack slot
  function automatic void byte_tick(int s);
    case (s)
      0: begin
        bits_left = 4'd8;
        clk_line = 1'b0;
      end
      1: clk_line = 1'b0;
      2: dio_line = shift_reg[0];
      3: begin
        clk_line = 1'b1;
        shift_reg = shift_reg >> 1;
        bits_left = bits_left - 4'd1;
      end
      4: clk_line = 1'b0;
      5: clk_line = 1'b1;
      7: clk_line = 1'b0;
      default: ;
    endcase
    // loop back to the clock-low step while bits remain
    if (s == 3 && bits_left != 0) seq_step = seq_step - 7'd2;
    else seq_step = seq_step + 7'd1;
  endfunction

  // one tick of a stop followed by a start
  function automatic void gap_tick(int s);
    case (s)
      0: dio_line = 1'b0;
      1: clk_line = 1'b1;
      2: dio_line = 1'b1;
      default: dio_line = 1'b0;
    endcase
    seq_step = seq_step + 7'd1;
  endfunction

  // line step for a tick; returns 1 when idle or complete
  function automatic logic advance_lines();
    int c;
    int d;
    int k;
    c = int'(seq_step);
    d = n_bytes * 8;
    if (!active || c >= 36 + d) begin
      active = 1'b0;
      return 1'b1;
    end
    if (c < 8) begin
      byte_tick(c);
    end else if (c < 12) begin
      gap_tick(c - 8);
    end else if (c < 20) begin
      if (c == 12) shift_reg = CMD_ADDR | {6'b0, digit_addr};
      byte_tick(c - 12);
    end else if (c < 20 + d) begin
      k = c - 20;
      if (k % 8 == 0) shift_reg = seg_store[k / 8];
      byte_tick(k % 8);
    end else if (c < 24 + d) begin
      gap_tick(c - (20 + d));
    end else if (c < 32 + d) begin
      if (c == 24 + d) shift_reg = CMD_CTRL | {4'b0, cfg_on, cfg_bright};
      byte_tick(c - (24 + d));
    end else begin
      gap_tick(c - (32 + d));
    end
    return 1'b0;
  endfunction

  // predicted line levels and done flag after one item
  function automatic line_result_t next_lines(tick_item_t it);
    line_result_t r;
    logic [2:0]   n;
    logic [7:0]   digits[4];
    r.done = 1'b0;
    if (it.req == REQ_START) begin
      n = (it.count > MAX_DATA_BYTES_DEF) ? 3'(MAX_DATA_BYTES_DEF) : it.count;
      digits = '{it.d0, it.d1, it.d2, it.d3};
      for (int i = 0; i < 4; i++) seg_store[i] = (i < n) ? digits[i] : 8'h00;
      n_bytes = n;
      digit_addr = it.pos;
      seq_step = '0;
      active = 1'b1;
      shift_reg = CMD_DATA;
      bits_left = 4'd8;
      dio_line = 1'b0;
    end else begin
      r.done = advance_lines();
    end
    r.clk_l = clk_line;
    r.dio_l = dio_line;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 100) $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // driver: offers queued items, holds payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_lines.push_back(next_lines(cur_item));
      if (!in_valid || !in_stall) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = tick_queue.pop_front();
          in_valid <= 1'b1;
          req_type <= cur_item.req;
          seg_digit0 <= cur_item.d0;
          seg_digit1 <= cur_item.d1;
          seg_digit2 <= cur_item.d2;
          seg_digit3 <= cur_item.d3;
          byte_count <= cur_item.count;
          start_position <= cur_item.pos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off counter
  always @(posedge clk) begin
    if (hold_start) hold_left <= LONG_HOLD;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    line_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        report("unexpected item", {29'b0, clk_level, dio_level, done_res}, 32'h0);
      end else begin
        want = expected_lines.pop_front();
        if (clk_level !== want.clk_l)
          report("clk_level", 32'(clk_level), 32'(want.clk_l));
        if (dio_level !== want.dio_l)
          report("dio_level", 32'(dio_level), 32'(want.dio_l));
        if (done_res !== want.done)
          report("done_res", 32'(done_res), 32'(want.done));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // register write through the config port
  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_BRIGHTNESS) cfg_bright = val[2:0];
    else cfg_on = val[0];
  endtask

  // register read, checked against the local copy
  task automatic reg_check(input logic idx);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_BRIGHTNESS) begin
      if (prdata[2:0] !== cfg_bright)
        report("brightness readback", prdata, 32'(cfg_bright));
    end else begin
      if (prdata[0] !== cfg_on) report("display_on readback", prdata, 32'(cfg_on));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_display(input logic [2:0] bright, input logic on);
    reg_write(REG_BRIGHTNESS, {29'b0, bright});
    reg_write(REG_DISPLAY_ON, {31'b0, on});
    reg_check(REG_BRIGHTNESS);
    reg_check(REG_DISPLAY_ON);
  endtask

  function automatic tick_item_t rand_item(logic req);
    tick_item_t  it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(tick_item_t)-1:0];
    it.req = req;
    return it;
  endfunction

  // one transfer: start, then ticks to completion or a cut-off, some noise
  function automatic int queue_transfer();
    tick_item_t st;
    int         n;
    int         len;
    int         added;
    st = rand_item(REQ_START);
    n = (st.count > MAX_DATA_BYTES_DEF) ? MAX_DATA_BYTES_DEF : st.count;
    len = 36 + 8 * n;
    if ($urandom_range(99) < 15) len = $urandom_range(len - 1, 1);
    else len = len + $urandom_range(4, 1);
    tick_queue.push_back(st);
    for (int i = 0; i < len; i++) tick_queue.push_back(rand_item(REQ_TICK));
    added = len + 1;
    if ($urandom_range(99) < 10) begin
      for (int i = 0; i < 3; i++) tick_queue.push_back(rand_item(1'($urandom_range(1))));
      added += 3;
    end
    return added;
  endfunction

  task automatic fill_random(int target);
    int count;
    count = 0;
    while (count < target) count += queue_transfer();
  endtask

  task automatic wait_drained();
    while (tick_queue.size() != 0 || in_valid || expected_lines.size() != 0)
      @(posedge clk);
  endtask

  // phases
  initial begin
    tick_item_t it;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    reg_check(REG_BRIGHTNESS);
    reg_check(REG_DISPLAY_ON);

    // directed: tick while idle, oversized count, restart mid-transfer
    tick_queue.push_back(rand_item(REQ_TICK));
    it = '{req: REQ_START, d0: 8'hFF, d1: 8'h00, d2: 8'hA5, d3: 8'h5A,
           count: 3'd7, pos: 2'd3};
    tick_queue.push_back(it);
    for (int i = 0; i < 16; i++) tick_queue.push_back(rand_item(REQ_TICK));
    it = '{req: REQ_START, d0: 8'h00, d1: 8'hFF, d2: 8'h00, d3: 8'hFF,
           count: 3'd0, pos: 2'd0};
    tick_queue.push_back(it);
    for (int i = 0; i < 6; i++) tick_queue.push_back(rand_item(REQ_TICK));
    wait_drained();

    // no idling, long output hold-off with the input backing up
    set_display(3'd0, 1'b0);
    send_idle_pct = 0;
    stall_pct = 0;
    fill_random(PHASE_ITEMS);
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    wait_drained();

    // sender idling
    set_display(3'd7, 1'b1);
    send_idle_pct = 53;
    stall_pct = 0;
    fill_random(PHASE_ITEMS);
    wait_drained();

    // receiver stalling
    set_display(3'($urandom_range(7)), 1'($urandom_range(1)));
    send_idle_pct = 0;
    stall_pct = 53;
    fill_random(PHASE_ITEMS);
    wait_drained();

    // both sides idling
    set_display(3'($urandom_range(7)), 1'($urandom_range(1)));
    send_idle_pct = 28;
    stall_pct = 28;
    fill_random(PHASE_ITEMS);
    wait_drained();

    repeat (5) @(posedge clk);
    if (mismatches == 0 && expected_lines.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
